[sv/salcp_pkg.sv]
// ----------------------------------------------------------------------------
// salcp_pkg
// Shared widths, codes and transaction types of the LCP array builder.
// ----------------------------------------------------------------------------
`default_nettype none

package salcp_pkg;

	localparam int MAX_LEN = 1024;
	localparam int IDX_W   = $clog2(MAX_LEN);
	localparam int LEN_W   = IDX_W + 1;
	localparam int BYTE_W  = 8;
	localparam int LCP_W   = 8;
	localparam int OP_W    = 2;

	localparam logic [LCP_W-1:0] LCP_SAT = 8'd255;

	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_COMPUTE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ    = 2'd2;

	localparam logic KIND_DONE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [IDX_W-1:0]  index;
		logic [BYTE_W-1:0] text_byte;
		logic [IDX_W-1:0]  suffix_pos;
		logic [LEN_W-1:0]  length;
	} cmd_t;

	typedef struct packed {
		logic              kind;
		logic [LCP_W-1:0]  lcp_value;
		logic [IDX_W-1:0]  read_index;
	} rsp_t;

endpackage

`default_nettype wire

[sv/salcp_engine.sv]
// ----------------------------------------------------------------------------
// salcp_engine
// Text, suffix, rank and LCP memories with the sequencer that runs the
// rank pass and the Kasai LCP pass one memory access step at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module salcp_engine (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_ready,
	input  wire salcp_pkg::cmd_t  cmd,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output salcp_pkg::rsp_t       rsp
);

	localparam int IDX_W  = salcp_pkg::IDX_W;
	localparam int LEN_W  = salcp_pkg::LEN_W;
	localparam int BYTE_W = salcp_pkg::BYTE_W;
	localparam int LCP_W  = salcp_pkg::LCP_W;
	localparam int DEPTH  = salcp_pkg::MAX_LEN;

	localparam logic [LEN_W-1:0] MAX_LEN_V = LEN_W'(DEPTH);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RANK_RD,
		S_RANK_WR,
		S_POS,
		S_PREV,
		S_J,
		S_CMP,
		S_TST,
		S_LCP_WR,
		S_RSP_DONE,
		S_RSP_READ
	} state_t;

	state_t state_q;

	logic [LEN_W-1:0] n_q;
	logic [LEN_W-1:0] i_q;
	logic [LEN_W-1:0] h_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] ridx_q;

	logic [BYTE_W-1:0] text_mem [DEPTH];
	logic [IDX_W-1:0]  sfx_mem  [DEPTH];
	logic [IDX_W-1:0]  rank_mem [DEPTH];
	logic [LCP_W-1:0]  lcp_mem  [DEPTH];

	logic [BYTE_W-1:0] text_a_q, text_b_q;
	logic [IDX_W-1:0]  sfx_rd_q, rank_rd_q;
	logic [LCP_W-1:0]  lcp_rd_q;

	logic              accept;
	logic              load_we;
	logic              rank_we;
	logic              lcp_we;
	logic [IDX_W-1:0]  lcp_wa;
	logic [LCP_W-1:0]  lcp_wd;
	logic              sfx_re;
	logic [IDX_W-1:0]  sfx_ra;
	logic              rank_re;
	logic              text_re;
	logic              lcp_re;
	logic [LEN_W:0]    sum_a;
	logic [LEN_W:0]    sum_b;
	logic              can_ext;
	logic              stop;
	logic [LCP_W-1:0]  h_sat;
	logic [LEN_W-1:0]  n_clip;

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;

	// shared adder/compare: both text positions and the range test
	assign sum_a   = {1'b0, i_q} + {1'b0, h_q};
	assign sum_b   = {2'b00, j_q} + {1'b0, h_q};
	assign can_ext = (sum_a < {1'b0, n_q}) && ({1'b0, j_q} < n_q)
		&& (sum_b < {1'b0, n_q});
	assign stop    = (text_a_q == '0) || (text_b_q == '0) || (text_a_q != text_b_q);
	assign h_sat   = (h_q > LEN_W'(LCP_SAT_EXT())) ? salcp_pkg::LCP_SAT : h_q[LCP_W-1:0];
	assign n_clip  = (cmd.length > MAX_LEN_V) ? MAX_LEN_V : cmd.length;

	function automatic logic [LEN_W-1:0] LCP_SAT_EXT();
		return LEN_W'(salcp_pkg::LCP_SAT);
	endfunction

	always_comb begin
		load_we = accept && (cmd.opcode == salcp_pkg::OP_LOAD);
		lcp_re  = accept && (cmd.opcode == salcp_pkg::OP_READ);
		rank_we = (state_q == S_RANK_WR);
		rank_re = (state_q == S_POS) && (i_q != n_q);
		text_re = (state_q == S_CMP) && can_ext;
		sfx_re  = 1'b0;
		sfx_ra  = i_q[IDX_W-1:0];
		lcp_we  = 1'b0;
		lcp_wa  = k_q;
		lcp_wd  = h_sat;
		case (state_q)
			S_IDLE: begin
				if (accept && (cmd.opcode == salcp_pkg::OP_COMPUTE)) begin
					lcp_we = 1'b1;
					lcp_wa = '0;
					lcp_wd = '0;
				end
			end
			S_RANK_RD: begin
				sfx_re = (i_q != n_q);
			end
			S_PREV: begin
				sfx_re = (rank_rd_q != '0);
				sfx_ra = rank_rd_q - IDX_W'(1);
			end
			S_LCP_WR: begin
				lcp_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			text_mem[cmd.index] <= cmd.text_byte;
			sfx_mem[cmd.index]  <= cmd.suffix_pos;
		end
		if (text_re) begin
			text_a_q <= text_mem[sum_a[IDX_W-1:0]];
			text_b_q <= text_mem[sum_b[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (sfx_re) begin
			sfx_rd_q <= sfx_mem[sfx_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (rank_we) begin
			rank_mem[sfx_rd_q] <= i_q[IDX_W-1:0];
		end
		if (rank_re) begin
			rank_rd_q <= rank_mem[i_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (lcp_we) begin
			lcp_mem[lcp_wa] <= lcp_wd;
		end
		if (lcp_re) begin
			lcp_rd_q <= lcp_mem[cmd.index];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			i_q     <= '0;
			h_q     <= '0;
			k_q     <= '0;
			j_q     <= '0;
			ridx_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.opcode)
							salcp_pkg::OP_COMPUTE: begin
								n_q     <= n_clip;
								i_q     <= '0;
								h_q     <= '0;
								state_q <= S_RANK_RD;
							end
							salcp_pkg::OP_READ: begin
								ridx_q  <= cmd.index;
								state_q <= S_RSP_READ;
							end
							default: begin
							end
						endcase
					end
				end
				S_RANK_RD: begin
					if (i_q == n_q) begin
						i_q     <= '0;
						state_q <= S_POS;
					end else begin
						state_q <= S_RANK_WR;
					end
				end
				S_RANK_WR: begin
					i_q     <= i_q + LEN_W'(1);
					state_q <= S_RANK_RD;
				end
				S_POS: begin
					state_q <= (i_q == n_q) ? S_RSP_DONE : S_PREV;
				end
				S_PREV: begin
					k_q <= rank_rd_q;
					if (rank_rd_q == '0) begin
						i_q     <= i_q + LEN_W'(1);
						state_q <= S_POS;
					end else begin
						state_q <= S_J;
					end
				end
				S_J: begin
					j_q <= sfx_rd_q;
					if (h_q > n_q) begin
						h_q <= n_q;
					end
					state_q <= S_CMP;
				end
				S_CMP: begin
					state_q <= can_ext ? S_TST : S_LCP_WR;
				end
				S_TST: begin
					if (stop) begin
						state_q <= S_LCP_WR;
					end else begin
						h_q     <= h_q + LEN_W'(1);
						state_q <= S_CMP;
					end
				end
				S_LCP_WR: begin
					if (h_q != '0) begin
						h_q <= h_q - LEN_W'(1);
					end
					i_q     <= i_q + LEN_W'(1);
					state_q <= S_POS;
				end
				S_RSP_DONE, S_RSP_READ: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		rsp_valid = (state_q == S_RSP_DONE) || (state_q == S_RSP_READ);
		if (state_q == S_RSP_READ) begin
			rsp.kind       = salcp_pkg::KIND_READ;
			rsp.lcp_value  = lcp_rd_q;
			rsp.read_index = ridx_q;
		end else begin
			rsp.kind       = salcp_pkg::KIND_DONE;
			rsp.lcp_value  = '0;
			rsp.read_index = '0;
		end
	end

endmodule

`default_nettype wire

[sv/suffix_array_lcp_builder.sv]
// ----------------------------------------------------------------------------
// suffix_array_lcp_builder
// Kasai LCP array builder over loaded text and suffix array, with a
// registered result port.
// ----------------------------------------------------------------------------
// A load transaction gives no result. A read gives its result through the
// engine's response state and the output register. A compute over n
// positions runs a rank pass and then an LCP pass, with its compare loop
// run once per matched character (at most about 2n matched characters over
// the whole pass), before its done result.
// The steps are single accesses to the suffix, rank or LCP memory, reads of
// two text positions, or tests; the character compare loop takes one text
// read and one test per character. No new transaction is taken while a
// read or compute is running; a finished result waits in the output register
// without blocking the next transaction. No clearing pass after reset.
`default_nettype none

module suffix_array_lcp_builder (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [salcp_pkg::OP_W-1:0]         opcode,
	input  wire logic [salcp_pkg::IDX_W-1:0]        index,
	input  wire logic [salcp_pkg::BYTE_W-1:0]       text_byte,
	input  wire logic [salcp_pkg::IDX_W-1:0]        suffix_pos,
	input  wire logic [salcp_pkg::LEN_W-1:0]        length,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    kind,
	output logic [salcp_pkg::LCP_W-1:0]             lcp_value,
	output logic [salcp_pkg::IDX_W-1:0]             read_index
);

	salcp_pkg::cmd_t cmd;
	salcp_pkg::rsp_t rsp;
	salcp_pkg::rsp_t out_q;
	logic            rsp_valid;
	logic            rsp_ready;
	logic            out_valid_q;

	assign cmd.opcode     = opcode;
	assign cmd.index      = index;
	assign cmd.text_byte  = text_byte;
	assign cmd.suffix_pos = suffix_pos;
	assign cmd.length     = length;

	salcp_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (in_valid),
		.cmd_ready (in_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	assign rsp_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_ready) begin
			out_valid_q <= rsp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_ready && rsp_valid) begin
			out_q <= rsp;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = out_q.kind;
	assign lcp_value  = out_q.lcp_value;
	assign read_index = out_q.read_index;

endmodule

`default_nettype wire

[verif/lcp_answer_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcp_answer_checker
// Watches both channels of the LCP array builder, keeps its own copy of the
// text, suffix, rank and LCP stores, works out the answer of every accepted
// transaction and compares each returned result with the oldest one due.
// ----------------------------------------------------------------------------
module lcp_answer_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_ready,
	input  wire logic [salcp_pkg::OP_W-1:0]     opcode,
	input  wire logic [salcp_pkg::IDX_W-1:0]    index,
	input  wire logic [salcp_pkg::BYTE_W-1:0]   text_byte,
	input  wire logic [salcp_pkg::IDX_W-1:0]    suffix_pos,
	input  wire logic [salcp_pkg::LEN_W-1:0]    length,
	input  wire logic                           out_valid,
	input  wire logic                           out_ready,
	input  wire logic                           kind,
	input  wire logic [salcp_pkg::LCP_W-1:0]    lcp_value,
	input  wire logic [salcp_pkg::IDX_W-1:0]    read_index,
	output int                                  mismatches,
	output int                                  answers_due
);

	localparam int MAX_LEN = salcp_pkg::MAX_LEN;
	localparam int IDX_W   = salcp_pkg::IDX_W;
	localparam int LEN_W   = salcp_pkg::LEN_W;
	localparam int BYTE_W  = salcp_pkg::BYTE_W;
	localparam int LCP_W   = salcp_pkg::LCP_W;

	logic [BYTE_W-1:0]  text_copy [MAX_LEN];
	logic [IDX_W-1:0]   sa_copy   [MAX_LEN];
	logic [IDX_W-1:0]   rank_copy [MAX_LEN];
	logic [LCP_W-1:0]   lcp_copy  [MAX_LEN];
	salcp_pkg::rsp_t    answer_q  [$];

	// Rank pass, then the LCP pass carrying the match length from one text
	// position to the next, less one.
	function automatic void kasai_fill(input logic [LEN_W-1:0] len_in);
		int n;
		int h;
		int k;
		int j;
		int p;
		logic [BYTE_W-1:0] ca;
		logic [BYTE_W-1:0] cb;
		n = (len_in > MAX_LEN) ? MAX_LEN : int'(len_in);
		h = 0;
		lcp_copy[0] = '0;
		for (p = 0; p < n; p++)
			rank_copy[sa_copy[p]] = p[IDX_W-1:0];
		for (p = 0; p < n; p++) begin
			k = int'(rank_copy[p]);
			if (k == 0)
				continue;
			j = int'(sa_copy[k-1]);
			if (h > n)
				h = n;
			while (p + h < n && j < n && j + h < n) begin
				ca = text_copy[p+h];
				cb = text_copy[j+h];
				if (ca == 8'h00 || cb == 8'h00 || ca != cb)
					break;
				h++;
			end
			lcp_copy[k] = (h > int'(salcp_pkg::LCP_SAT)) ? salcp_pkg::LCP_SAT
				: h[LCP_W-1:0];
			if (h > 0)
				h--;
		end
	endfunction

	task automatic check_field(input string name, input logic [15:0] expv,
		input logic [15:0] actv);
		if (actv !== expv) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$time, name, expv, actv);
		end
	endtask

	always @(posedge clk) begin
		salcp_pkg::rsp_t want;
		if (arst_n) begin
			// results first: a result never belongs to a transaction taken at the same edge
			if (out_valid && out_ready) begin
				if (answer_q.size() == 0) begin
					mismatches++;
					$display("%0t ns: unexpected result, expected none, actual kind=%0d lcp=%0d index=%0d",
						$time, kind, lcp_value, read_index);
				end else begin
					want = answer_q.pop_front();
					check_field("kind", 16'(want.kind), 16'(kind));
					check_field("lcp_value", 16'(want.lcp_value), 16'(lcp_value));
					check_field("read_index", 16'(want.read_index), 16'(read_index));
				end
			end
			if (in_valid && in_ready) begin
				case (opcode)
					salcp_pkg::OP_LOAD: begin
						text_copy[index] = text_byte;
						sa_copy[index]   = suffix_pos;
					end
					salcp_pkg::OP_COMPUTE: begin
						kasai_fill(length);
						want.kind       = salcp_pkg::KIND_DONE;
						want.lcp_value  = '0;
						want.read_index = '0;
						answer_q.push_back(want);
					end
					salcp_pkg::OP_READ: begin
						want.kind       = salcp_pkg::KIND_READ;
						want.lcp_value  = lcp_copy[index];
						want.read_index = index;
						answer_q.push_back(want);
					end
					default: ;
				endcase
			end
			answers_due = answer_q.size();
		end
	end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the LCP array builder: a directed opening, then rounds of
// text and suffix-array loads, computes and reads, mostly with properly
// sorted suffix arrays, and one full-size round. Stores are only read after
// they were written. Answers are checked by lcp_answer_checker.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MAX_LEN = salcp_pkg::MAX_LEN;
	localparam int IDX_W   = salcp_pkg::IDX_W;
	localparam int LEN_W   = salcp_pkg::LEN_W;
	localparam int BYTE_W  = salcp_pkg::BYTE_W;
	localparam int LCP_W   = salcp_pkg::LCP_W;
	localparam int OP_W    = salcp_pkg::OP_W;

	localparam int CLK_PERIOD   = 8;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int SMALL_ITEMS  = 150;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 64;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	logic [OP_W-1:0]    opcode     = salcp_pkg::OP_LOAD;
	logic [IDX_W-1:0]   index      = '0;
	logic [BYTE_W-1:0]  text_byte  = '0;
	logic [IDX_W-1:0]   suffix_pos = '0;
	logic [LEN_W-1:0]   length     = '0;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	logic               kind;
	logic [LCP_W-1:0]   lcp_value;
	logic [IDX_W-1:0]   read_index;
	int                 mismatches;
	int                 answers_due;

	int tx_idle_pct   = 24;
	int rx_idle_pct   = 24;
	int hold_off_reqs = 0;
	int items_sent    = 0;

	// what has been written so far, so no unwritten entry is ever read
	logic [BYTE_W-1:0] text_shadow [MAX_LEN];
	logic [IDX_W-1:0]  sa_shadow   [MAX_LEN];
	bit                rank_set    [MAX_LEN];
	bit                lcp_set     [MAX_LEN];

	suffix_array_lcp_builder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.index      (index),
		.text_byte  (text_byte),
		.suffix_pos (suffix_pos),
		.length     (length),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.lcp_value  (lcp_value),
		.read_index (read_index)
	);

	lcp_answer_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.index       (index),
		.text_byte   (text_byte),
		.suffix_pos  (suffix_pos),
		.length      (length),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.lcp_value   (lcp_value),
		.read_index  (read_index),
		.mismatches  (mismatches),
		.answers_due (answers_due)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("Some tests failed");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int held;
		int holds_done;
		forever begin
			@(posedge clk);
			if (hold_off_reqs != holds_done) begin
				holds_done++;
				out_ready <= 1'b0;
				for (held = 1; held < HOLD_CYCLES; held++)
					@(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic offer(input logic [OP_W-1:0] op, input int idx, input int ch,
		input int spos, input int len);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		index      <= idx[IDX_W-1:0];
		text_byte  <= ch[BYTE_W-1:0];
		suffix_pos <= spos[IDX_W-1:0];
		length     <= len[LEN_W-1:0];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic send_load(input int idx, input logic [BYTE_W-1:0] ch, input int spos);
		text_shadow[idx] = ch;
		sa_shadow[idx]   = spos[IDX_W-1:0];
		offer(salcp_pkg::OP_LOAD, idx, int'(ch), spos, $urandom_range(2047));
	endtask

	task automatic send_read(input int idx);
		offer(salcp_pkg::OP_READ, idx, $urandom_range(255), $urandom_range(1023),
			$urandom_range(2047));
	endtask

	task automatic send_junk();
		offer(OP_UNUSED, $urandom_range(1023), $urandom_range(255), $urandom_range(1023),
			$urandom_range(2047));
	endtask

	// LCP entry 0 is always marked as known, the others only when the suffix array is a permutation
	task automatic send_compute(input int len);
		int n;
		bit seen [MAX_LEN];
		bit perm;
		n = (len > MAX_LEN) ? MAX_LEN : len;
		perm = 1'b1;
		lcp_set[0] = 1'b1;
		for (int p = 0; p < n; p++) begin
			rank_set[sa_shadow[p]] = 1'b1;
			if (sa_shadow[p] >= n || seen[sa_shadow[p]])
				perm = 1'b0;
			seen[sa_shadow[p]] = 1'b1;
		end
		if (perm)
			for (int p = 0; p < n; p++)
				lcp_set[p] = 1'b1;
		offer(salcp_pkg::OP_COMPUTE, $urandom_range(1023), $urandom_range(255),
			$urandom_range(1023), len);
	endtask

	// every rank read by a compute must be set now or by an earlier compute
	function automatic bit compute_safe(input int n);
		bit covered [MAX_LEN];
		for (int p = 0; p < n; p++)
			covered[sa_shadow[p]] = 1'b1;
		for (int p = 0; p < n; p++)
			if (!covered[p] && !rank_set[p])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic int written_lcp(input int hi);
		int pick;
		for (int tries = 0; tries < 32; tries++) begin
			pick = $urandom_range(hi);
			if (lcp_set[pick])
				return pick;
		end
		return 0;
	endfunction

	// end of text sorts before any character
	function automatic bit suffix_less(input int a, input int b, input int n);
		for (int q = 0; q <= n; q++) begin
			if (b + q >= n)
				return 1'b0;
			if (a + q >= n)
				return 1'b1;
			if (text_shadow[a+q] != text_shadow[b+q])
				return text_shadow[a+q] < text_shadow[b+q];
		end
		return 1'b0;
	endfunction

	task automatic sort_suffixes(input int n);
		int ins;
		int pick;
		int order [MAX_LEN];
		for (int p = 0; p < n; p++)
			order[p] = p;
		for (int p = 1; p < n; p++) begin
			ins  = order[p];
			pick = p;
			while (pick > 0 && suffix_less(ins, order[pick-1], n)) begin
				order[pick] = order[pick-1];
				pick--;
			end
			order[pick] = ins;
		end
		for (int p = 0; p < n; p++)
			sa_shadow[p] = order[p][IDX_W-1:0];
	endtask

	task automatic shuffle(inout int order [MAX_LEN], input int n);
		int pick;
		int tmp;
		for (int p = 0; p < n; p++)
			order[p] = p;
		for (int p = n - 1; p > 0; p--) begin
			pick        = $urandom_range(p);
			tmp         = order[p];
			order[p]    = order[pick];
			order[pick] = tmp;
		end
	endtask

	task automatic small_round();
		int n;
		int kinds;
		int style;
		int order [MAX_LEN];
		logic [BYTE_W-1:0] alphabet [4];
		n     = $urandom_range(2, 40);
		kinds = $urandom_range(1, 4);
		style = $urandom_range(9);
		for (int a = 0; a < 4; a++)
			alphabet[a] = BYTE_W'($urandom_range(1, 255));
		for (int p = 0; p < n; p++)
			text_shadow[p] = ($urandom_range(19) == 0) ? 8'h00
				: alphabet[$urandom_range(kinds - 1)];
		// mostly a real suffix array, else shuffled, else damaged
		if (style < 7) begin
			sort_suffixes(n);
		end else begin
			shuffle(order, n);
			for (int p = 0; p < n; p++)
				sa_shadow[p] = order[p][IDX_W-1:0];
			if (style == 9) begin
				for (int c = 0; c < 3; c++)
					sa_shadow[$urandom_range(n - 1)] = IDX_W'($urandom_range(1023));
				if (!compute_safe(n))
					for (int p = 0; p < n; p++)
						sa_shadow[p] = order[p][IDX_W-1:0];
			end
		end
		shuffle(order, n);
		for (int p = 0; p < n; p++) begin
			if ($urandom_range(99) < 12)
				send_read(written_lcp(MAX_LEN - 1));
			if ($urandom_range(99) < 4)
				send_junk();
			send_load(order[p], text_shadow[order[p]], int'(sa_shadow[order[p]]));
		end
		send_compute(n);
		repeat (n / 2 + 1)
			send_read(written_lcp(n - 1));
	endtask

	initial begin
		logic [BYTE_W-1:0] ch;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening: empty compute, unused opcode, byte extremes,
		// a terminator inside the text, a suffix entry past the length, n = 1
		send_compute(0);
		send_read(0);
		send_junk();
		text_shadow[0] = 8'hFF;
		text_shadow[1] = 8'h01;
		text_shadow[2] = 8'hFF;
		text_shadow[3] = 8'h01;
		sort_suffixes(4);
		for (int p = 0; p < 4; p++)
			send_load(p, text_shadow[p], int'(sa_shadow[p]));
		send_compute(4);
		for (int p = 0; p < 4; p++)
			send_read(p);
		send_load(1, 8'h00, int'(sa_shadow[1]));
		send_load(0, 8'hFF, MAX_LEN - 1);
		send_load(MAX_LEN - 1, 8'h7F, 0);
		send_compute(4);
		for (int p = 0; p < 4; p++)
			send_read(p);
		send_compute(1);
		send_read(0);

		while (items_sent < SMALL_ITEMS)
			small_round();

		// full size, one repeated character: long matches and saturation
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		ch = BYTE_W'($urandom_range(1, 255));
		for (int p = 0; p < MAX_LEN; p++)
			send_load(p, ch, MAX_LEN - 1 - p);
		send_compute(MAX_LEN);
		tx_idle_pct = 24;
		rx_idle_pct = 24;
		send_read(MAX_LEN - 1);
		send_read(255);
		send_read(256);
		repeat (20)
			send_read($urandom_range(MAX_LEN - 1));
		send_compute(2047);
		hold_off_reqs++;
		repeat (40)
			send_read($urandom_range(MAX_LEN - 1));
		repeat (6) begin
			send_compute($urandom_range(2047));
			repeat (8)
				send_read(written_lcp(MAX_LEN - 1));
		end
		in_valid <= 1'b0;

		while (answers_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && answers_due == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
